// ----- rtl/core/sample_voice_interpolating_player_top_macros.svh -----
`ifndef SAMPLE_VOICE_INTERPOLATING_PLAYER_TOP_MACROS_SVH
`define SAMPLE_VOICE_INTERPOLATING_PLAYER_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante (uses the module's clk and rst_n).
`define SVIP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define SVIP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/svip_pkg.sv -----
package svip_pkg;

  // Defaults for the top-level parameters
  localparam int VOICES_DEF           = 4;
  localparam int SAMPLE_MEM_BYTES_DEF = 524288;

  // Stream widths
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 16;

  // Field widths
  localparam int POS_W       = 34;
  localparam int FRAC_W      = 16;
  localparam int IDX_W       = POS_W - FRAC_W;
  localparam int LEN_W       = 17;
  localparam int ADDR_IN_W   = 19;
  localparam int STEP_W      = 17;
  localparam int VOL_W       = 7;
  localparam int TREM_W      = 5;
  localparam int VOICE_W     = 2;
  localparam int VOICE_EXT_W = 6;

  // Levels and limits
  localparam logic [7:0]       MID_LEVEL  = 8'h80;
  localparam logic [LEN_W-1:0] MIN_LOOP   = 17'd4;
  localparam logic [VOL_W-1:0] MAX_VOLUME = 7'd64;

  // Result queue depth (power of two)
  localparam int OQ_DEPTH = 8;

  // Request kinds
  localparam logic [1:0] OP_WRITE    = 2'd0;
  localparam logic [1:0] OP_TRIGGER  = 2'd1;
  localparam logic [1:0] OP_SET_STEP = 2'd2;
  localparam logic [1:0] OP_ADVANCE  = 2'd3;

  // How an advance forms its sample
  localparam logic [1:0] KIND_SILENT = 2'd0;
  localparam logic [1:0] KIND_EASE   = 2'd1;
  localparam logic [1:0] KIND_INTERP = 2'd2;

  typedef struct packed {
    logic [1:0]           op;
    logic [VOICE_W-1:0]   voice;
    logic [ADDR_IN_W-1:0] address;
    logic [7:0]           data_byte;
    logic [LEN_W-1:0]     sample_length;
    logic [LEN_W-1:0]     loop_start;
    logic [LEN_W-1:0]     loop_length;
    logic [7:0]           start_page;
    logic [STEP_W-1:0]    step;
    logic [VOL_W-1:0]     volume;
    logic [TREM_W-1:0]    tremolo_delta;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0]     pos;
    logic [STEP_W-1:0]    step;
    logic [ADDR_IN_W-1:0] base;
    logic [LEN_W-1:0]     len;
    logic [LEN_W-1:0]     ls;
    logic [LEN_W-1:0]     ll;
  } voice_entry_t;

  // Voice stage to sample fetch
  typedef struct packed {
    logic [1:0]           op;
    logic [VOICE_W-1:0]   voice;
    logic [1:0]           kind;
    logic [VOL_W-1:0]     vol;
    logic [IDX_W-1:0]     idx;
    logic [FRAC_W-1:0]    frac;
    logic                 looped;
    logic [IDX_W-1:0]     loop_end;
    logic [LEN_W-1:0]     loop_len;
    logic [LEN_W-1:0]     last_idx;
    logic [ADDR_IN_W-1:0] base;
    logic [ADDR_IN_W-1:0] address;
    logic [7:0]           data_byte;
  } s2_t;

endpackage

// ----- rtl/core/svip_voice.sv -----
module svip_voice #(
  parameter int VOICES = svip_pkg::VOICES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  svip_pkg::item_t in_item,
  output logic            s2_vld_o,
  output svip_pkg::s2_t   s2_o
);
  import svip_pkg::*;

`include "sample_voice_interpolating_player_top_macros.svh"

  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

  // Voice table: one synchronous read at accept, one write from the update stage
  voice_entry_t vmem [VOICES];
  logic [VOICES-1:0] vmem_vld_r;

  voice_entry_t rd_data_r;
  logic         rd_vld_r;
  logic         fwd_hit_r;
  voice_entry_t fwd_data_r;

  logic  s1_vld_r;
  item_t s1_item_r;

  logic [VOICE_EXT_W-1:0] in_vext;
  logic [VIDX_W-1:0]      in_idx;
  logic [VOICE_EXT_W-1:0] s1_vext;
  logic [VIDX_W-1:0]      s1_idx;
  logic                   voice_ok;

  voice_entry_t cur;
  voice_entry_t nxt;
  logic         wr_en;
  logic [1:0]   kind;

  logic [POS_W-1:0] pos_sum;
  logic [POS_W-1:0] pos_wrap;
  logic [IDX_W-1:0] loop_end;
  logic             looped;
  logic             past_loop;
  logic             past_end;
  logic [LEN_W-1:0] last_idx;
  logic [7:0]       vol_sum;
  logic [VOL_W-1:0] vol_clamp;

  logic  s2_vld_r;
  s2_t   s2_r;
  s2_t   s2_nxt;

  logic adv_interp_oneshot;
  logic oneshot_idx_ok;

  assign in_vext = VOICE_EXT_W'(in_item.voice);
  assign in_idx  = in_vext[VIDX_W-1:0];
  assign s1_vext = VOICE_EXT_W'(s1_item_r.voice);
  assign s1_idx  = s1_vext[VIDX_W-1:0];
  assign voice_ok = s1_vext < VOICE_EXT_W'(VOICES);

  // Read the voice entry as the request enters; write back the updated entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      vmem[s1_idx] <= nxt;
    end
    rd_data_r  <= vmem[in_idx];
    fwd_data_r <= nxt;
    s1_item_r  <= in_item;
  end

  // Track written entries and the read-during-write case
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vmem_vld_r <= '0;
      rd_vld_r   <= 1'b0;
      fwd_hit_r  <= 1'b0;
      s1_vld_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        vmem_vld_r[s1_idx] <= 1'b1;
      end
      rd_vld_r  <= vmem_vld_r[in_idx];
      fwd_hit_r <= wr_en && (s1_idx == in_idx);
      s1_vld_r  <= in_vld;
    end
  end

  // Take the freshest copy of the entry; an unwritten entry reads as zero
  always_comb begin
    if (fwd_hit_r) begin
      cur = fwd_data_r;
    end else if (rd_vld_r) begin
      cur = rd_data_r;
    end else begin
      cur = '0;
    end
  end

  // Position arithmetic
  assign pos_sum   = cur.pos + POS_W'(cur.step);
  assign pos_wrap  = pos_sum - {1'b0, cur.ll, {FRAC_W{1'b0}}};
  assign loop_end  = {1'b0, cur.ls} + {1'b0, cur.ll};
  assign looped    = cur.ll >= MIN_LOOP;
  assign past_loop = pos_sum >= {loop_end, {FRAC_W{1'b0}}};
  assign past_end  = pos_sum[POS_W-1:FRAC_W] >= {1'b0, cur.len};
  assign last_idx  = cur.len - LEN_W'(1);

  // Clamp volume plus tremolo
  assign vol_sum   = {1'b0, s1_item_r.volume} + {3'b0, s1_item_r.tremolo_delta};
  assign vol_clamp = (vol_sum > {1'b0, MAX_VOLUME}) ? MAX_VOLUME : vol_sum[VOL_W-1:0];

  // Apply the request to the voice entry
  always_comb begin
    nxt   = cur;
    wr_en = 1'b0;
    kind  = KIND_SILENT;
    case (s1_item_r.op)
      OP_TRIGGER: begin
        if (voice_ok) begin
          wr_en    = 1'b1;
          nxt.base = s1_item_r.address;
          nxt.len  = s1_item_r.sample_length;
          nxt.ls   = s1_item_r.loop_start;
          nxt.ll   = s1_item_r.loop_length;
          nxt.pos  = {2'b0, s1_item_r.start_page, 24'b0};
          nxt.step = s1_item_r.step;
        end
      end
      OP_SET_STEP: begin
        if (voice_ok) begin
          wr_en    = 1'b1;
          nxt.step = s1_item_r.step;
        end
      end
      OP_ADVANCE: begin
        if (voice_ok && (cur.len != '0)) begin
          if (cur.step == '0) begin
            kind = KIND_EASE;
          end else if (looped) begin
            wr_en   = 1'b1;
            kind    = KIND_INTERP;
            nxt.pos = past_loop ? pos_wrap : pos_sum;
          end else if (past_end) begin
            wr_en    = 1'b1;
            kind     = KIND_EASE;
            nxt.pos  = {1'b0, last_idx, {FRAC_W{1'b0}}};
            nxt.step = '0;
          end else begin
            wr_en   = 1'b1;
            kind    = KIND_INTERP;
            nxt.pos = pos_sum;
          end
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
    wr_en = wr_en && s1_vld_r;
  end

  // Hand the read plan to the sample fetch
  always_comb begin
    s2_nxt.op        = s1_item_r.op;
    s2_nxt.voice     = s1_item_r.voice;
    s2_nxt.kind      = kind;
    s2_nxt.vol       = (kind == KIND_SILENT) ? '0 : vol_clamp;
    s2_nxt.idx       = nxt.pos[POS_W-1:FRAC_W];
    s2_nxt.frac      = nxt.pos[FRAC_W-1:0];
    s2_nxt.looped    = looped;
    s2_nxt.loop_end  = loop_end;
    s2_nxt.loop_len  = cur.ll;
    s2_nxt.last_idx  = last_idx;
    s2_nxt.base      = cur.base;
    s2_nxt.address   = s1_item_r.address;
    s2_nxt.data_byte = s1_item_r.data_byte;
  end

  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  assign s2_vld_o = s2_vld_r;
  assign s2_o     = s2_r;

  assign adv_interp_oneshot = s1_vld_r && (s1_item_r.op == OP_ADVANCE) &&
                              (kind == KIND_INTERP) && !looped;
  assign oneshot_idx_ok = nxt.pos[POS_W-1:FRAC_W] < {1'b0, cur.len};

  `SVIP_ASSERT_IMP(a_wr_voice_in_range, wr_en, voice_ok, "voice table write for missing voice")
  `SVIP_ASSERT_IMP(a_oneshot_inside, adv_interp_oneshot, oneshot_idx_ok, "one-shot position past end")

endmodule

// ----- rtl/core/sample_voice_interpolating_player_top.sv -----
// Sampled-sound player: a byte sample memory and VOICES voices, driven by a request stream
// (in_tuser selects write byte, trigger, set step or advance). Each advance returns one
// result (0x80-centered sample, interpolated or eased toward the midpoint, and clamped volume); other requests return
// nothing. One request is taken per clock when results are drained: the voice table is
// read as a request enters and written back in the cycle after, with the just-written entry
// forwarded to the next request, so requests for the same voice follow back to back. The
// sample memory has one write port and two registered read ports, giving both neighboring
// bytes of an advance in the same cycle. An advance's result passes stages s1 to s5 into
// an eight-entry result queue that absorbs output stalls, and in_tready drops only
// when eight advances are pending. SAMPLE_MEM_BYTES must be a power of two; addresses wrap
// modulo it. Sample bytes that were never written read as unknown.
module sample_voice_interpolating_player_top #(
  parameter int VOICES           = svip_pkg::VOICES_DEF,
  parameter int SAMPLE_MEM_BYTES = svip_pkg::SAMPLE_MEM_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // voice[1:0], address[20:2], data_byte[28:21], sample_length[45:29],
  // loop_start[62:46], loop_length[79:63], start_page[87:80], step[104:88],
  // volume[111:105], tremolo_delta[116:112], zero[119:117]
  input  logic [svip_pkg::IN_DATA_W-1:0]  in_tdata,
  // op[1:0]
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // sample_out[7:0], volume_out[14:8], zero[15]
  output logic [svip_pkg::OUT_DATA_W-1:0] out_tdata
);
  import svip_pkg::*;

`include "sample_voice_interpolating_player_top_macros.svh"

  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int ADDR_W = $clog2(SAMPLE_MEM_BYTES);
  localparam int SUM_W  = ADDR_IN_W + 1;
  localparam int EXT_W  = (ADDR_W > SUM_W) ? ADDR_W : SUM_W;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int CRED_W   = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [1:0]           op;
    logic [VOICE_W-1:0]   voice;
    logic [1:0]           kind;
    logic [VOL_W-1:0]     vol;
    logic [FRAC_W-1:0]    frac;
    logic [IDX_W-1:0]     idx_a;
    logic [IDX_W:0]       idx_b;
    logic [LEN_W-1:0]     last_idx;
    logic [ADDR_IN_W-1:0] base;
    logic [ADDR_IN_W-1:0] address;
    logic [7:0]           data_byte;
  } s3_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [VOICE_W-1:0] voice;
    logic [1:0]         kind;
    logic [VOL_W-1:0]   vol;
    logic [FRAC_W-1:0]  frac;
  } s4_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [VOICE_W-1:0] voice;
    logic [1:0]         kind;
    logic [VOL_W-1:0]   vol;
    logic [7:0]         a;
    logic [25:0]        prod;
  } s5_t;

  item_t item;
  logic  in_acc;
  logic  acc_adv;
  logic  pop;

  logic  s2_vld;
  s2_t   s2;

  // Unpack the request
  always_comb begin
    item.op            = in_tuser;
    item.voice         = in_tdata[1:0];
    item.address       = in_tdata[20:2];
    item.data_byte     = in_tdata[28:21];
    item.sample_length = in_tdata[45:29];
    item.loop_start    = in_tdata[62:46];
    item.loop_length   = in_tdata[79:63];
    item.start_page    = in_tdata[87:80];
    item.step          = in_tdata[104:88];
    item.volume        = in_tdata[111:105];
    item.tremolo_delta = in_tdata[116:112];
  end

  assign in_acc  = in_tvalid && in_tready;
  assign acc_adv = in_acc && (in_tuser == OP_ADVANCE);

  svip_voice #(
    .VOICES (VOICES)
  ) u_voice (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_acc),
    .in_item  (item),
    .s2_vld_o (s2_vld),
    .s2_o     (s2)
  );

  // Wrap both read indices once at the loop end
  logic [IDX_W-1:0] idx_a;
  logic [IDX_W:0]   idx_b_raw;
  logic [IDX_W:0]   idx_b;
  s3_t              s3_nxt;
  s3_t              s3_r;
  logic             s3_vld_r;

  assign idx_b_raw = {1'b0, s2.idx} + (IDX_W + 1)'(1);

  always_comb begin
    if (s2.looped && (s2.idx >= s2.loop_end)) begin
      idx_a = s2.idx - IDX_W'(s2.loop_len);
    end else begin
      idx_a = s2.idx;
    end
    if (s2.looped && (idx_b_raw >= {1'b0, s2.loop_end})) begin
      idx_b = idx_b_raw - (IDX_W + 1)'(s2.loop_len);
    end else begin
      idx_b = idx_b_raw;
    end
    s3_nxt.op        = s2.op;
    s3_nxt.voice     = s2.voice;
    s3_nxt.kind      = s2.kind;
    s3_nxt.vol       = s2.vol;
    s3_nxt.frac      = s2.frac;
    s3_nxt.idx_a     = idx_a;
    s3_nxt.idx_b     = idx_b;
    s3_nxt.last_idx  = s2.last_idx;
    s3_nxt.base      = s2.base;
    s3_nxt.address   = s2.address;
    s3_nxt.data_byte = s2.data_byte;
  end

  always_ff @(posedge clk) begin
    s3_r <= s3_nxt;
  end

  // Clamp to the last byte and form the memory addresses
  logic [LEN_W-1:0]  clamp_a;
  logic [LEN_W-1:0]  clamp_b;
  logic [SUM_W-1:0]  sum_a;
  logic [SUM_W-1:0]  sum_b;
  logic [EXT_W-1:0]  ext_a;
  logic [EXT_W-1:0]  ext_b;
  logic [EXT_W-1:0]  ext_w;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;
  logic [ADDR_W-1:0] addr_w;
  logic              smem_we;

  assign clamp_a = (s3_r.idx_a > {1'b0, s3_r.last_idx}) ? s3_r.last_idx
                                                         : s3_r.idx_a[LEN_W-1:0];
  assign clamp_b = (s3_r.idx_b > {2'b0, s3_r.last_idx}) ? s3_r.last_idx
                                                         : s3_r.idx_b[LEN_W-1:0];
  assign sum_a   = {1'b0, s3_r.base} + SUM_W'(clamp_a);
  assign sum_b   = {1'b0, s3_r.base} + SUM_W'(clamp_b);
  assign ext_a   = EXT_W'(sum_a);
  assign ext_b   = EXT_W'(sum_b);
  assign ext_w   = EXT_W'(s3_r.address);
  assign addr_a  = ext_a[ADDR_W-1:0];
  assign addr_b  = ext_b[ADDR_W-1:0];
  assign addr_w  = ext_w[ADDR_W-1:0];
  assign smem_we = s3_vld_r && (s3_r.op == OP_WRITE);

  // Sample memory: one write, two registered reads
  logic [7:0] smem [SAMPLE_MEM_BYTES];
  logic [7:0] rd_a_r;
  logic [7:0] rd_b_r;
  s4_t        s4_r;
  logic       s4_vld_r;

  always_ff @(posedge clk) begin
    if (smem_we) begin
      smem[addr_w] <= s3_r.data_byte;
    end
    rd_a_r <= smem[addr_a];
    rd_b_r <= smem[addr_b];
  end

  always_ff @(posedge clk) begin
    s4_r.op    <= s3_r.op;
    s4_r.voice <= s3_r.voice;
    s4_r.kind  <= s3_r.kind;
    s4_r.vol   <= s3_r.vol;
    s4_r.frac  <= s3_r.frac;
  end

  // Center the bytes and scale their difference by the fraction
  logic [7:0]         cen_a;
  logic [7:0]         cen_b;
  logic signed [8:0]  diff_s;
  logic signed [25:0] prod_s;
  s5_t                s5_r;
  logic               s5_vld_r;

  assign cen_a  = rd_a_r ^ MID_LEVEL;
  assign cen_b  = rd_b_r ^ MID_LEVEL;
  assign diff_s = $signed({1'b0, cen_b}) - $signed({1'b0, cen_a});
  assign prod_s = 26'(diff_s) * 26'($signed({1'b0, s4_r.frac}));

  always_ff @(posedge clk) begin
    s5_r.op    <= s4_r.op;
    s5_r.voice <= s4_r.voice;
    s5_r.kind  <= s4_r.kind;
    s5_r.vol   <= s4_r.vol;
    s5_r.a     <= cen_a;
    s5_r.prod  <= prod_s;
  end

  // Finish the sample: interpolate, ease toward the midpoint, or stay silent
  logic [7:0]             last_out_r [VOICES];
  logic [VOICE_EXT_W-1:0] s5_vext;
  logic [VIDX_W-1:0]      s5_idx;
  logic [7:0]             last_cur;
  logic signed [9:0]      shift_s;
  logic signed [10:0]     value_s;
  logic [7:0]             interp_val;
  logic signed [8:0]      dist_s;
  logic signed [8:0]      half_s;
  logic [8:0]             eased9;
  logic [7:0]             res_sample;
  logic                   last_we;
  logic                   push;

  assign s5_vext  = VOICE_EXT_W'(s5_r.voice);
  assign s5_idx   = s5_vext[VIDX_W-1:0];
  assign last_cur = last_out_r[s5_idx];

  assign shift_s = $signed(s5_r.prod[25:16]);
  assign value_s = $signed({3'b0, s5_r.a}) + $signed({shift_s[9], shift_s});

  always_comb begin
    if (value_s < 0) begin
      interp_val = 8'd0;
    end else if (value_s > 11'sd255) begin
      interp_val = 8'd255;
    end else begin
      interp_val = value_s[7:0];
    end
  end

  assign dist_s = $signed({1'b0, last_cur}) - $signed({1'b0, MID_LEVEL});
  assign half_s = (dist_s + $signed({8'b0, dist_s[8]})) >>> 1;
  assign eased9 = $unsigned(half_s) + {1'b0, MID_LEVEL};

  assign push = s5_vld_r && (s5_r.op == OP_ADVANCE);

  always_comb begin
    case (s5_r.kind)
      KIND_EASE:   res_sample = eased9[7:0];
      KIND_INTERP: res_sample = interp_val;
      default:     res_sample = MID_LEVEL;
    endcase
  end

  assign last_we = push && ((s5_r.kind == KIND_EASE) || (s5_r.kind == KIND_INTERP));

  // Hold the last output of each voice
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        last_out_r[i] <= MID_LEVEL;
      end
    end else if (last_we) begin
      last_out_r[s5_idx] <= res_sample;
    end
  end

  // Advance the stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  // Result queue
  logic [OUT_DATA_W-1:0] oq_mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   oq_wr_ptr_r;
  logic [OQ_PTR_W-1:0]   oq_rd_ptr_r;
  logic [CRED_W-1:0]     oq_count_r;
  logic [CRED_W-1:0]     oq_count_nxt;
  logic [CRED_W-1:0]     cred_r;
  logic [CRED_W-1:0]     cred_nxt;
  logic                  oq_has_room;

  assign out_tvalid = oq_count_r != '0;
  assign out_tdata  = oq_mem[oq_rd_ptr_r];
  assign pop        = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      oq_mem[oq_wr_ptr_r] <= {1'b0, s5_r.vol, res_sample};
    end
  end

  assign oq_count_nxt = oq_count_r + CRED_W'(push) - CRED_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_ptr_r <= '0;
      oq_rd_ptr_r <= '0;
      oq_count_r  <= '0;
    end else begin
      if (push) begin
        oq_wr_ptr_r <= oq_wr_ptr_r + OQ_PTR_W'(1);
      end
      if (pop) begin
        oq_rd_ptr_r <= oq_rd_ptr_r + OQ_PTR_W'(1);
      end
      oq_count_r <= oq_count_nxt;
    end
  end

  // Reserve a queue slot for every advance in flight
  assign cred_nxt  = cred_r + CRED_W'(acc_adv) - CRED_W'(pop);
  assign in_tready = cred_r < CRED_W'(OQ_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r <= '0;
    end else begin
      cred_r <= cred_nxt;
    end
  end

  assign oq_has_room = oq_count_r < CRED_W'(OQ_DEPTH);

  `SVIP_ASSERT_IMP(a_queue_within_credit, 1'b1, oq_count_r <= cred_r, "queue exceeds slots")
  `SVIP_ASSERT_IMP(a_push_has_room, push, oq_has_room, "result pushed into a full queue")
  `SVIP_ASSERT_NXT(a_adv_takes_slot, acc_adv && !pop,
                   cred_r == $past(cred_r) + CRED_W'(1), "advance without slot")

endmodule
